// ===== rtl/sae_pkg.sv =====
// Shared types and constants for the scalar ALU execute block.
package sae_pkg;

    localparam int DATA_W      = 32;
    localparam int REG_W       = 6;
    localparam int REG_COUNT   = 64;
    localparam int DIV_STEPS   = DATA_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        MODE_ADD    = 5'd0,
        MODE_SUB    = 5'd1,
        MODE_MUL    = 5'd2,
        MODE_DIV    = 5'd3,
        MODE_SLL    = 5'd4,
        MODE_SRL    = 5'd5,
        MODE_SRA    = 5'd6,
        MODE_MOD    = 5'd7,
        MODE_MIN    = 5'd8,
        MODE_MAX    = 5'd9,
        MODE_AND    = 5'd10,
        MODE_OR     = 5'd11,
        MODE_EQ     = 5'd12,
        MODE_NE     = 5'd13,
        MODE_GT     = 5'd14,
        MODE_LT     = 5'd15,
        MODE_LUI    = 5'd16,
        MODE_LOAD   = 5'd17,
        MODE_STORE  = 5'd18,
        MODE_ASSIGN = 5'd19
    } mode_t;

    // Classified request as it leaves the front end.
    typedef struct packed {
        mode_t              mode;
        logic [DATA_W-1:0]  a;
        logic [DATA_W-1:0]  b;
        logic [DATA_W-1:0]  off;
        logic [REG_W-1:0]   num;
        logic               is_special;
        logic               wr;
    } op_t;

    // Partial result carried alongside the divider.
    typedef struct packed {
        logic               wr;
        logic [REG_W-1:0]   num;
        logic               is_special;
        logic [DATA_W-1:0]  v;
        logic               mrd;
        logic               mwr;
        logic [DATA_W-1:0]  addr;
        logic [DATA_W-1:0]  data;
        logic               is_div;
        logic               is_mod;
        logic               na;
        logic               nb;
        logic               bz;
    } res_t;

endpackage

// ===== rtl/scalar_alu_execute.sv =====
// Top level of the scalar ALU execute block.
//
//  channel   handshake         fields
//  -------   ---------------   ----------------------------------------------
//  request   start / busy      mode, operands, offset, destination, binding
//  result    done (strobe)     register write, memory request, values
//
// A request is taken at a rising edge with start high and busy low. One
// request can enter every cycle while busy is low. Each request passes through
// the queue, the ALU stage register fed from the queue head, 32 stages of
// the pipelined divider (one quotient bit per stage), and the output register.
// All operations take the same path, so results leave in request order.
// Reset clears the queue and the valid bits of every stage; no pass over
// storage is needed. The receiver cannot stall, so the back end drains the
// queue every cycle and busy only rises if the queue were ever full.
module scalar_alu_execute (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [4:0]                  mode,
    input  logic signed [31:0]          first_operand,
    input  logic signed [31:0]          second_operand,
    input  logic signed [31:0]          address_offset,
    input  logic [5:0]                  dest_register,
    input  logic                        to_special,
    input  logic                        bound_present,
    input  logic [5:0]                  bound_register,
    output logic                        done,
    output logic                        reg_write,
    output logic [5:0]                  reg_number,
    output logic                        reg_is_special,
    output logic signed [31:0]          result_value,
    output logic                        mem_read,
    output logic                        mem_write,
    output logic signed [31:0]          mem_address,
    output logic signed [31:0]          mem_data
);

    sae_pkg::op_t   front_op;
    sae_pkg::op_t   queue_op;
    logic           queue_full;
    logic           queue_not_empty;
    sae_pkg::res_t  res;

    // The front end classifies the request and resolves its destination.
    sae_front u_front (
        .mode           (mode),
        .first_operand  (first_operand),
        .second_operand (second_operand),
        .address_offset (address_offset),
        .dest_register  (dest_register),
        .to_special     (to_special),
        .bound_present  (bound_present),
        .bound_register (bound_register),
        .op             (front_op)
    );

    // The queue decouples acceptance from execution.
    sae_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start),
        .push_op   (front_op),
        .pop       (queue_not_empty),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .pop_op    (queue_op)
    );

    assign busy = queue_full;

    // The back end executes one request per cycle.
    sae_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_not_empty),
        .op        (queue_op),
        .out_valid (done),
        .out_res   (res)
    );

    assign reg_write      = res.wr;
    assign reg_number     = res.num;
    assign reg_is_special = res.is_special;
    assign result_value   = res.v;
    assign mem_read       = res.mrd;
    assign mem_write      = res.mwr;
    assign mem_address    = res.addr;
    assign mem_data       = res.data;

endmodule

// ===== rtl/sae_front.sv =====
// Front end: classifies a request and resolves its destination register.
module sae_front (
    input  logic [4:0]                        mode,
    input  logic [sae_pkg::DATA_W-1:0]        first_operand,
    input  logic [sae_pkg::DATA_W-1:0]        second_operand,
    input  logic [sae_pkg::DATA_W-1:0]        address_offset,
    input  logic [sae_pkg::REG_W-1:0]         dest_register,
    input  logic                              to_special,
    input  logic                              bound_present,
    input  logic [sae_pkg::REG_W-1:0]         bound_register,
    output sae_pkg::op_t                      op
);

    sae_pkg::mode_t m;
    logic           wr;
    logic [sae_pkg::REG_W-1:0] num;
    logic           spec;

    always_comb
    begin
        m    = sae_pkg::mode_t'(mode);
        wr   = 1'b1;
        num  = dest_register;
        spec = 1'b0;
        case (m) inside
            sae_pkg::MODE_ADD, sae_pkg::MODE_SUB, sae_pkg::MODE_MUL, sae_pkg::MODE_DIV,
            sae_pkg::MODE_SLL, sae_pkg::MODE_SRL, sae_pkg::MODE_SRA, sae_pkg::MODE_MOD,
            sae_pkg::MODE_MIN, sae_pkg::MODE_MAX, sae_pkg::MODE_AND, sae_pkg::MODE_OR,
            sae_pkg::MODE_EQ, sae_pkg::MODE_NE, sae_pkg::MODE_GT, sae_pkg::MODE_LT,
            sae_pkg::MODE_LUI: ;
            sae_pkg::MODE_LOAD:  wr = 1'b0;
            sae_pkg::MODE_STORE:
            begin
                wr  = 1'b0;
                num = '0;
            end
            sae_pkg::MODE_ASSIGN:
            begin
                spec = to_special;
                if (to_special && bound_present)
                begin
                    num  = bound_register;
                    spec = 1'b0;
                end
            end
            default:
            begin
                wr  = 1'b0;
                num = '0;
            end
        endcase
        // A destination beyond the register file suppresses the write.
        if ({3'b000, num} >= 9'(sae_pkg::REG_COUNT))
        begin
            wr = 1'b0;
        end
        op.mode       = m;
        op.a          = first_operand;
        op.b          = second_operand;
        op.off        = address_offset;
        op.num        = num;
        op.is_special = spec;
        op.wr         = wr;
    end

endmodule

// ===== rtl/sae_queue.sv =====
// Short queue of classified requests between the front and back ends.
module sae_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sae_pkg::op_t  push_op,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output sae_pkg::op_t  pop_op
);

    sae_pkg::op_t                 entry_reg [sae_pkg::QUEUE_DEPTH];
    logic [sae_pkg::QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [sae_pkg::QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [sae_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                         do_push, do_pop;

    assign full      = (count_reg == sae_pkg::QCNT_W'(sae_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_op    = entry_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == sae_pkg::QPTR_W'(sae_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == sae_pkg::QPTR_W'(sae_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_op;
        end
    end

endmodule

// ===== rtl/sae_div.sv =====
// Pipelined restoring divider on unsigned magnitudes, one quotient bit per stage.
module sae_div (
    input  logic                       clk,
    input  logic [sae_pkg::DATA_W-1:0] dividend,
    input  logic [sae_pkg::DATA_W-1:0] divisor,
    output logic [sae_pkg::DATA_W-1:0] quotient,
    output logic [sae_pkg::DATA_W-1:0] remainder
);

    localparam int W = sae_pkg::DATA_W;
    localparam int N = sae_pkg::DIV_STEPS;

    logic [W-1:0] r_reg [N];
    logic [W-1:0] q_reg [N];
    logic [W-1:0] d_reg [N];
    logic [W-1:0] r_next [N];
    logic [W-1:0] q_next [N];
    logic [W-1:0] d_next [N];

    always_comb
    begin
        logic [W-1:0] r_in, q_in, d_in;
        logic [W:0]   trial;
        for (int s = 0; s < N; s++)
        begin
            if (s == 0)
            begin
                r_in = '0;
                q_in = dividend;
                d_in = divisor;
            end
            else
            begin
                r_in = r_reg[s-1];
                q_in = q_reg[s-1];
                d_in = d_reg[s-1];
            end
            trial = {r_in, q_in[W-1]};
            if (trial >= {1'b0, d_in})
            begin
                r_next[s] = W'(trial - {1'b0, d_in});
                q_next[s] = {q_in[W-2:0], 1'b1};
            end
            else
            begin
                r_next[s] = trial[W-1:0];
                q_next[s] = {q_in[W-2:0], 1'b0};
            end
            d_next[s] = d_in;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < N; s++)
        begin
            r_reg[s] <= r_next[s];
            q_reg[s] <= q_next[s];
            d_reg[s] <= d_next[s];
        end
    end

    assign quotient  = q_reg[N-1];
    assign remainder = r_reg[N-1];

endmodule

// ===== rtl/sae_back.sv =====
// Back end: ALU stage, divider pipeline and the registered result ports.
module sae_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  sae_pkg::op_t                op,
    output logic                        out_valid,
    output sae_pkg::res_t               out_res
);

    localparam int W = sae_pkg::DATA_W;
    localparam int N = sae_pkg::DIV_STEPS;

    sae_pkg::res_t   res_next, stage_reg;
    logic            stage_valid_reg;
    logic [W-1:0]    ua_next, ub_next, ua_reg, ub_reg;
    sae_pkg::res_t   line_reg [N];
    logic            line_valid_reg [N];
    logic [W-1:0]    quo, rem;
    sae_pkg::res_t   fin_next, fin_reg;
    logic            fin_valid_reg;

    always_comb
    begin
        logic [4:0] sh;
        logic       lt_ab, lt_ba;
        sh    = op.b[4:0];
        lt_ab = $signed(op.a) < $signed(op.b);
        lt_ba = $signed(op.b) < $signed(op.a);
        res_next            = '0;
        res_next.wr         = op.wr;
        res_next.num        = op.num;
        res_next.is_special = op.is_special;
        res_next.na         = op.a[W-1];
        res_next.nb         = op.b[W-1];
        res_next.bz         = (op.b == '0);
        ua_next = op.a[W-1] ? (~op.a + 1'b1) : op.a;
        ub_next = op.b[W-1] ? (~op.b + 1'b1) : op.b;
        case (op.mode)
            sae_pkg::MODE_ADD:  res_next.v = op.a + op.b;
            sae_pkg::MODE_SUB:  res_next.v = op.a - op.b;
            sae_pkg::MODE_MUL:  res_next.v = op.a * op.b;
            sae_pkg::MODE_DIV:
            begin
                res_next.is_div = 1'b1;
                res_next.v      = '1;
            end
            sae_pkg::MODE_MOD:
            begin
                res_next.is_mod = 1'b1;
                res_next.v      = op.a;
            end
            sae_pkg::MODE_SLL:  res_next.v = op.a << sh;
            sae_pkg::MODE_SRL:  res_next.v = op.a >> sh;
            sae_pkg::MODE_SRA:  res_next.v = W'($signed(op.a) >>> sh);
            sae_pkg::MODE_MIN:  res_next.v = lt_ab ? op.a : op.b;
            sae_pkg::MODE_MAX:  res_next.v = lt_ab ? op.b : op.a;
            sae_pkg::MODE_AND:  res_next.v = op.a & op.b;
            sae_pkg::MODE_OR:   res_next.v = op.a | op.b;
            sae_pkg::MODE_EQ:   res_next.v = W'(op.a == op.b);
            sae_pkg::MODE_NE:   res_next.v = W'(op.a != op.b);
            sae_pkg::MODE_GT:   res_next.v = W'(lt_ba);
            sae_pkg::MODE_LT:   res_next.v = W'(lt_ab);
            sae_pkg::MODE_LUI:  res_next.v = op.b << 16;
            sae_pkg::MODE_LOAD:
            begin
                res_next.mrd  = 1'b1;
                res_next.addr = op.a + op.off;
            end
            sae_pkg::MODE_STORE:
            begin
                res_next.mwr  = 1'b1;
                res_next.addr = op.a + op.off;
                res_next.data = op.b;
            end
            sae_pkg::MODE_ASSIGN: res_next.v = op.a;
            default: ;
        endcase
    end

    sae_div u_div (
        .clk       (clk),
        .dividend  (ua_reg),
        .divisor   (ub_reg),
        .quotient  (quo),
        .remainder (rem)
    );

    always_comb
    begin
        sae_pkg::res_t r;
        r        = line_reg[N-1];
        fin_next = r;
        if (!r.bz)
        begin
            if (r.is_div)
            begin
                fin_next.v = (r.na != r.nb) ? (~quo + 1'b1) : quo;
            end
            else if (r.is_mod)
            begin
                fin_next.v = r.na ? (~rem + 1'b1) : rem;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            fin_valid_reg   <= 1'b0;
            for (int s = 0; s < N; s++)
            begin
                line_valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            stage_valid_reg <= in_valid;
            line_valid_reg[0] <= stage_valid_reg;
            for (int s = 1; s < N; s++)
            begin
                line_valid_reg[s] <= line_valid_reg[s-1];
            end
            fin_valid_reg <= line_valid_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg   <= res_next;
        ua_reg      <= ua_next;
        ub_reg      <= ub_next;
        line_reg[0] <= stage_reg;
        for (int s = 1; s < N; s++)
        begin
            line_reg[s] <= line_reg[s-1];
        end
        fin_reg <= fin_next;
    end

    assign out_valid = fin_valid_reg;
    assign out_res   = fin_reg;

endmodule

// ===== tb/sae_checker.sv =====
// Checker that predicts and compares every scalar ALU result.
`timescale 1ns / 1ps
module sae_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [4:0]         mode,
    input  logic signed [31:0] first_operand,
    input  logic signed [31:0] second_operand,
    input  logic signed [31:0] address_offset,
    input  logic [5:0]         dest_register,
    input  logic               to_special,
    input  logic               bound_present,
    input  logic [5:0]         bound_register,
    input  logic               done,
    input  logic               reg_write,
    input  logic [5:0]         reg_number,
    input  logic               reg_is_special,
    input  logic signed [31:0] result_value,
    input  logic               mem_read,
    input  logic               mem_write,
    input  logic signed [31:0] mem_address,
    input  logic signed [31:0] mem_data,
    output int                 fail_count,
    output int                 pending_count,
    output int                 result_count
);

    typedef struct packed {
        logic        wr;
        logic [5:0]  num;
        logic        spec;
        logic [31:0] value;
        logic        rd;
        logic        wt;
        logic [31:0] addr;
        logic [31:0] data;
    } outcome_t;

    outcome_t expected_q[$];

    function automatic logic [31:0] signed_divide(logic [31:0] a, logic [31:0] b,
                                                  bit want_rem);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        logic [31:0] r;
        if (b == 0)
            return want_rem ? a : 32'hFFFF_FFFF;
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q = ua / ub;
        r = ua % ub;
        if (want_rem)
            return a[31] ? -r : r;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic outcome_t execute_request(logic [4:0] m, logic [31:0] a,
        logic [31:0] b, logic [31:0] off, logic [5:0] dst, logic sp, logic bp,
        logic [5:0] bnd);
        outcome_t o;
        logic [4:0] sh;
        sh = b[4:0];
        o = '0;
        o.wr = 1'b1;
        o.num = dst;
        case (m)
            sae_pkg::MODE_ADD:   o.value = a + b;
            sae_pkg::MODE_SUB:   o.value = a - b;
            sae_pkg::MODE_MUL:   o.value = a * b;
            sae_pkg::MODE_DIV:   o.value = signed_divide(a, b, 1'b0);
            sae_pkg::MODE_SLL:   o.value = a << sh;
            sae_pkg::MODE_SRL:   o.value = a >> sh;
            sae_pkg::MODE_SRA:   o.value = $signed(a) >>> sh;
            sae_pkg::MODE_MOD:   o.value = signed_divide(a, b, 1'b1);
            sae_pkg::MODE_MIN:   o.value = ($signed(a) < $signed(b)) ? a : b;
            sae_pkg::MODE_MAX:   o.value = ($signed(a) < $signed(b)) ? b : a;
            sae_pkg::MODE_AND:   o.value = a & b;
            sae_pkg::MODE_OR:    o.value = a | b;
            sae_pkg::MODE_EQ:    o.value = {31'd0, a == b};
            sae_pkg::MODE_NE:    o.value = {31'd0, a != b};
            sae_pkg::MODE_GT:    o.value = {31'd0, $signed(b) < $signed(a)};
            sae_pkg::MODE_LT:    o.value = {31'd0, $signed(a) < $signed(b)};
            sae_pkg::MODE_LUI:   o.value = b << 16;
            sae_pkg::MODE_LOAD:
            begin
                o.wr = 1'b0;
                o.rd = 1'b1;
                o.addr = a + off;
            end
            sae_pkg::MODE_STORE:
            begin
                o.wr = 1'b0;
                o.num = '0;
                o.wt = 1'b1;
                o.addr = a + off;
                o.data = b;
            end
            sae_pkg::MODE_ASSIGN:
            begin
                o.value = a;
                o.spec = sp;
                if (sp && bp)
                begin
                    o.num = bnd;
                    o.spec = 1'b0;
                end
            end
            default:
            begin
                o.wr = 1'b0;
                o.num = '0;
            end
        endcase
        // A destination beyond the register file drops the write.
        if (o.wr && ({26'd0, o.num} >= 32'(sae_pkg::REG_COUNT)))
            o.wr = 1'b0;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got;
        outcome_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            result_count <= 0;
            expected_q.delete();
        end
        else
        begin
            if (done)
            begin
                got = '{reg_write, reg_number, reg_is_special, result_value,
                        mem_read, mem_write, mem_address, mem_data};
                result_count <= result_count + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: expected wr=%b num=%0d sp=%b val=%h rd=%b wt=%b addr=%h data=%h",
                                 $time, want.wr, want.num, want.spec, want.value,
                                 want.rd, want.wt, want.addr, want.data);
                        $display("%0t: actual   wr=%b num=%0d sp=%b val=%h rd=%b wt=%b addr=%h data=%h",
                                 $time, got.wr, got.num, got.spec, got.value,
                                 got.rd, got.wt, got.addr, got.data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(execute_request(mode, first_operand,
                    second_operand, address_offset, dest_register, to_special,
                    bound_present, bound_register));
        end
    end

    assign pending_count = expected_q.size();

endmodule

// ===== tb/tb.sv =====
// Top of the scalar ALU execute testbench: stimulus, timeout and verdict.
`timescale 1ns / 1ps
module tb;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [4:0]         mode;
    logic signed [31:0] first_operand;
    logic signed [31:0] second_operand;
    logic signed [31:0] address_offset;
    logic [5:0]         dest_register;
    logic               to_special;
    logic               bound_present;
    logic [5:0]         bound_register;
    logic               done;
    logic               reg_write;
    logic [5:0]         reg_number;
    logic               reg_is_special;
    logic signed [31:0] result_value;
    logic               mem_read;
    logic               mem_write;
    logic signed [31:0] mem_address;
    logic signed [31:0] mem_data;
    int                 fail_count;
    int                 pending_count;
    int                 result_count;

    // Percentage of cycles in which the request side holds off.
    int                 idle_pct;
    int                 request_count;

    // The block has no configuration registers; every run is one setting.
    scalar_alu_execute dut (.*);
    sae_checker checker_i (.*);

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Every result passes through the same pipeline, so even the 1551 requests
    // with heavy idling finish far below this bound.
    initial
    begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

    // Operand drawn mostly from corner values, the rest fully random.
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'd0;
            4: return $urandom_range(0, 40);
            5: return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    // Present one request and hold it until the block takes it. Idle
    // cycles are inserted before it at the current rate. Busy is looked at
    // in the middle of the cycle, where it is settled.
    task automatic send_request(logic [4:0] m, logic [31:0] a, logic [31:0] b,
        logic [31:0] off, logic [5:0] dst, logic sp, logic bp, logic [5:0] bnd);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start          <= 1'b1;
        mode           <= m;
        first_operand  <= a;
        second_operand <= b;
        address_offset <= off;
        dest_register  <= dst;
        to_special     <= sp;
        bound_present  <= bp;
        bound_register <= bnd;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        request_count++;
    endtask

    task automatic send_random_request();
        logic [4:0] m;
        // Unknown modes appear now and then; the rest spread over all.
        m = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(20, 31))
                                         : 5'($urandom_range(0, 19));
        send_request(m, pick_operand(), pick_operand(), pick_operand(),
                     6'($urandom), 1'($urandom), 1'($urandom), 6'($urandom));
    endtask

    // Hold the request side idle until every expected result has come or the guard runs out.
    task automatic drain();
        int guard;
        start <= 1'b0;
        guard = 0;
        @(posedge clk);
        while (pending_count != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        mode = '0;
        first_operand = '0;
        second_operand = '0;
        address_offset = '0;
        dest_register = '0;
        to_special = 1'b0;
        bound_present = 1'b0;
        bound_register = '0;
        idle_pct = 0;
        request_count = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: division corners, arithmetic overflow, shift limits, min and max,
        // logic ops, compares, LUI, memory requests, assign routing and an unknown mode.
        send_request(sae_pkg::MODE_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0, 1, 0, 0, 0);
        send_request(sae_pkg::MODE_MOD, 32'h8000_0000, 32'hFFFF_FFFF, 0, 2, 0, 0, 0);
        send_request(sae_pkg::MODE_DIV, 32'd77, 32'd0, 0, 3, 0, 0, 0);
        send_request(sae_pkg::MODE_MOD, -32'sd77, 32'd0, 0, 4, 0, 0, 0);
        send_request(sae_pkg::MODE_DIV, -32'sd7, 32'd2, 0, 5, 0, 0, 0);
        send_request(sae_pkg::MODE_MOD, -32'sd7, 32'd2, 0, 6, 0, 0, 0);
        send_request(sae_pkg::MODE_ADD, 32'h7FFF_FFFF, 32'd1, 0, 63, 0, 0, 0);
        send_request(sae_pkg::MODE_SUB, 32'h8000_0000, 32'd1, 0, 0, 0, 0, 0);
        send_request(sae_pkg::MODE_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 7, 0, 0, 0);
        send_request(sae_pkg::MODE_SLL, 32'hFFFF_FFFF, 32'h0000_003F, 0, 8, 0, 0, 0);
        send_request(sae_pkg::MODE_SRL, 32'h8000_0000, 32'hFFFF_FFE1, 0, 9, 0, 0, 0);
        send_request(sae_pkg::MODE_SRA, 32'h8000_0000, 32'd31, 0, 10, 0, 0, 0);
        send_request(sae_pkg::MODE_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 0, 11, 0, 0, 0);
        send_request(sae_pkg::MODE_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 0, 12, 0, 0, 0);
        send_request(sae_pkg::MODE_AND, 32'hF0F0_F0F0, 32'hFF00_FF00, 0, 13, 0, 0, 0);
        send_request(sae_pkg::MODE_OR, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 0, 14, 0, 0, 0);
        send_request(sae_pkg::MODE_EQ, 32'd5, 32'd5, 0, 15, 0, 0, 0);
        send_request(sae_pkg::MODE_NE, 32'd5, 32'd5, 0, 16, 0, 0, 0);
        send_request(sae_pkg::MODE_GT, 32'd1, 32'hFFFF_FFFF, 0, 17, 0, 0, 0);
        send_request(sae_pkg::MODE_LT, 32'h8000_0000, 32'd0, 0, 18, 0, 0, 0);
        send_request(sae_pkg::MODE_LUI, 0, 32'hFFFF_FFFF, 0, 19, 0, 0, 0);
        send_request(sae_pkg::MODE_LOAD, 32'hFFFF_FFFC, 0, 32'd8, 20, 1, 1, 33);
        send_request(sae_pkg::MODE_STORE, 32'h7FFF_FFFF, 32'hDEAD_BEEF, 32'd1,
                     21, 0, 0, 0);
        send_request(sae_pkg::MODE_ASSIGN, 32'h1234_5678, 0, 0, 22, 1, 0, 44);
        send_request(sae_pkg::MODE_ASSIGN, 32'h1234_5678, 0, 0, 23, 1, 1, 44);
        send_request(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 63, 1, 1, 63);
        // Let every result come back before the random part starts.
        drain();

        idle_pct = 15;
        repeat (500) send_random_request();
        drain();
        idle_pct = 53;
        repeat (500) send_random_request();
        idle_pct = 0;
        repeat (525) send_random_request();
        drain();
        repeat (40) @(posedge clk);

        $display("Covered %0d requests over all modes, including unknown ones,", request_count);
        $display("with %0d results checked under three idling rates.", result_count);
        if (fail_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== scalar_alu_execute.f =====
rtl/sae_pkg.sv
rtl/sae_front.sv
rtl/sae_queue.sv
rtl/sae_div.sv
rtl/sae_back.sv
rtl/scalar_alu_execute.sv
tb/sae_checker.sv
tb/tb.sv
